// ----- rtl/srd_pkg.sv -----
`default_nettype none

package srd_pkg;

   // field widths
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned StampWidth  = 31;
   localparam int unsigned SpanWidth   = 20;
   localparam int unsigned LimitWidth  = 8;
   localparam int unsigned ShotWidth   = 9;
   localparam int unsigned FoundWidth  = 13;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned CsrAddrWidth = 2;

   // packed stream widths
   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned RspDataWidth = 112;
   localparam int unsigned RspUserWidth = 3;

   // run thresholds
   localparam logic [StampWidth-1:0] MinRunFrames = 31'd10;
   localparam logic [FoundWidth-1:0] MaxRegions   = 13'd4096;

   // reset values of the control registers
   localparam logic [SpanWidth-1:0]  MinSpanReset  = 20'd0;
   localparam logic [LimitWidth-1:0] ShotLimitReset = 8'd25;

   // register indexes
   typedef enum logic [CsrAddrWidth-1:0] {
      REG_MIN_SPAN_CS     = 2'd0,
      REG_SHOT_LIMIT      = 2'd1,
      REG_LENGTH_AS_SPAN  = 2'd2,
      REG_START_IN_WARMUP = 2'd3
   } csr_index_type;

   // result status codes
   typedef enum logic [StatusWidth-1:0] {
      STATUS_CONTINUE = 2'd0,
      STATUS_STOP     = 2'd1,
      STATUS_FLUSHED  = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/silence_region_detector_top.sv -----
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------------
// req      | in        | req_tvalid/tready    | tdata time_cs, tuser silent, tlast flush
// rsp      | out       | rsp_tvalid/tready    | tdata region fields + count, tuser status
// csr      | in        | csr_we, no wait      | csr_addr index, csr_wdata value
//
// the whole frame update is one pass of compare/subtract
// logic from the state registers into the result register, so a request
// accepted at one edge has its response valid right after it
// sustained rate is one request per cycle, set by the single result register:
// req_tready is high while that register is empty or being drained
// synchronous active-high reset loads the default control registers and the
// run tracker; a request with a negative time stamp answers stop and changes nothing

module silence_region_detector_top (
   input  wire                                clock,
   input  wire                                reset,
   // request stream
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [srd_pkg::ReqDataWidth-1:0]   req_tdata,  // [31:0] time_cs (signed)
   input  wire                                req_tuser,  // [0] silent
   input  wire                                req_tlast,  // flush_req
   // response stream
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [30:0] region_begin_cs, [61:31] region_end_cs, [92:62] region_length,
   // [105:93] regions_found, [111:106] zero
   output logic [srd_pkg::RspDataWidth-1:0]   rsp_tdata,
   // [1:0] status, [2] region_valid
   output logic [srd_pkg::RspUserWidth-1:0]   rsp_tuser,
   // control register writes
   input  wire                                csr_we,
   input  wire  [srd_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  wire  [srd_pkg::SpanWidth-1:0]      csr_wdata
);

   // control registers
   logic [srd_pkg::SpanWidth-1:0]  min_span_ff,  min_span_in;
   logic [srd_pkg::LimitWidth-1:0] shot_limit_ff, shot_limit_in;
   logic                           len_span_ff,  len_span_in;
   logic                           warm_start_ff, warm_start_in;

   // run tracker state
   logic [srd_pkg::StampWidth-1:0] run_length_ff, run_length_in;
   logic [srd_pkg::ShotWidth-1:0]  shot_ff,       shot_in;
   logic [srd_pkg::StampWidth-1:0] run_begin_ff,  run_begin_in;
   logic [srd_pkg::StampWidth-1:0] run_end_ff,    run_end_in;
   logic [srd_pkg::FoundWidth-1:0] found_ff,      found_in;
   logic                           flushing_ff,   flushing_in;
   logic                           warming_ff,    warming_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [srd_pkg::RspDataWidth-1:0] rsp_data_ff, rsp_data_in;
   logic [srd_pkg::RspUserWidth-1:0] rsp_user_ff, rsp_user_in;

   logic                           req_accept;
   logic [srd_pkg::StampWidth-1:0] stamp;
   logic                           negative;
   logic                           flush_now;
   logic [srd_pkg::TimeWidth-1:0]  span;
   logic                           span_ok;
   logic [srd_pkg::StampWidth-1:0] region_len;
   logic [srd_pkg::ShotWidth-1:0]  shot_mid;
   logic [srd_pkg::FoundWidth-1:0] found_mid;
   logic                           emit;
   srd_pkg::status_type            status;

   // a new request goes in whenever the result register is free or drains now
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign stamp     = req_tdata[srd_pkg::StampWidth-1:0];
   assign negative  = req_tdata[srd_pkg::TimeWidth-1];
   assign flush_now = flushing_ff || req_tlast;

   // span of the open run, may go negative when time runs backwards
   assign span    = {1'b0, run_end_ff} - {1'b0, run_begin_ff};
   assign span_ok = !span[srd_pkg::TimeWidth-1]
                    && (span[srd_pkg::StampWidth-1:0]
                        >= {{(srd_pkg::StampWidth-srd_pkg::SpanWidth){1'b0}}, min_span_ff});
   assign region_len = len_span_ff ? span[srd_pkg::StampWidth-1:0] : run_length_ff;

   // frame update
   always_comb begin
      run_length_in = run_length_ff;
      shot_in       = shot_ff;
      run_begin_in  = run_begin_ff;
      run_end_in    = run_end_ff;
      found_in      = found_ff;
      flushing_in   = flushing_ff;
      warming_in    = warming_ff;
      shot_mid      = shot_ff;
      found_mid     = found_ff;
      emit          = 1'b0;
      status        = srd_pkg::STATUS_CONTINUE;

      if (negative) begin
         status = srd_pkg::STATUS_STOP;
      end else begin
         flushing_in = flush_now;
         if (!flush_now && req_tuser) begin
            // silent frame extends the run
            if (run_length_ff == '0) begin
               run_begin_in = stamp;
            end
            if (!warming_ff && (run_length_ff != '1)) begin
               run_length_in = run_length_ff + 1'b1;
            end
            if (shot_ff < {1'b0, shot_limit_ff}) begin
               shot_in = shot_ff + 2'd2;
            end
            run_end_in = stamp;
         end else begin
            if (run_length_ff > srd_pkg::MinRunFrames) begin
               // long enough run closes when the counter reaches zero or on flush
               if (flush_now || (shot_ff == '0)) begin
                  if (span_ok && (found_ff < srd_pkg::MaxRegions)) begin
                     emit      = 1'b1;
                     found_mid = found_ff + 1'b1;
                  end
                  run_length_in = '0;
                  shot_mid      = {1'b0, shot_limit_ff};
               end
            end else begin
               run_length_in = '0;
            end
            found_in = found_mid;
            if (flush_now) begin
               shot_in = shot_mid;
               status  = srd_pkg::STATUS_FLUSHED;
            end else begin
               if (warming_ff && (shot_mid == '0)) begin
                  warming_in = 1'b0;
               end
               shot_in = (shot_mid != '0) ? shot_mid - 1'b1 : shot_mid;
               status  = (found_mid >= srd_pkg::MaxRegions) ? srd_pkg::STATUS_STOP
                                                            : srd_pkg::STATUS_CONTINUE;
            end
         end
      end
   end

   // result packing, region fields zero when nothing is emitted
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[30:0]    = emit ? run_begin_ff : '0;
      rsp_data_in[61:31]   = emit ? run_end_ff : '0;
      rsp_data_in[92:62]   = emit ? region_len : '0;
      rsp_data_in[105:93]  = found_in;
      rsp_user_in          = {emit, status};
      rsp_valid_in         = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control register writes, also reload the counter and warm-up flag
   always_comb begin
      min_span_in   = min_span_ff;
      shot_limit_in = shot_limit_ff;
      len_span_in   = len_span_ff;
      warm_start_in = warm_start_ff;
      if (csr_we) begin
         unique case (srd_pkg::csr_index_type'(csr_addr))
            srd_pkg::REG_MIN_SPAN_CS:     min_span_in   = csr_wdata;
            srd_pkg::REG_SHOT_LIMIT:      shot_limit_in = csr_wdata[srd_pkg::LimitWidth-1:0];
            srd_pkg::REG_LENGTH_AS_SPAN:  len_span_in   = csr_wdata[0];
            srd_pkg::REG_START_IN_WARMUP: warm_start_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_span_ff   <= srd_pkg::MinSpanReset;
         shot_limit_ff <= srd_pkg::ShotLimitReset;
         len_span_ff   <= 1'b0;
         warm_start_ff <= 1'b1;
         run_length_ff <= '0;
         shot_ff       <= {1'b0, srd_pkg::ShotLimitReset};
         run_begin_ff  <= '0;
         run_end_ff    <= '0;
         found_ff      <= '0;
         flushing_ff   <= 1'b0;
         warming_ff    <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         min_span_ff   <= min_span_in;
         shot_limit_ff <= shot_limit_in;
         len_span_ff   <= len_span_in;
         warm_start_ff <= warm_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_accept) begin
            run_length_ff <= run_length_in;
            shot_ff       <= shot_in;
            run_begin_ff  <= run_begin_in;
            run_end_ff    <= run_end_in;
            found_ff      <= found_in;
            flushing_ff   <= flushing_in;
            warming_ff    <= warming_in;
         end
         // register writes must come only while idle; the block does not enforce it
         if (csr_we && (srd_pkg::csr_index_type'(csr_addr) == srd_pkg::REG_SHOT_LIMIT)) begin
            shot_ff <= {1'b0, shot_limit_in};
         end
         if (csr_we
             && (srd_pkg::csr_index_type'(csr_addr) == srd_pkg::REG_START_IN_WARMUP)) begin
            warming_ff <= warm_start_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ----- tb/srd_region_checker.sv -----
module srd_region_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   input  wire                                req_tready,
   input  wire  [srd_pkg::ReqDataWidth-1:0]   req_tdata,   // [31:0] time_cs
   input  wire                                req_tuser,   // [0] silent
   input  wire                                req_tlast,   // flush_req
   input  wire                                rsp_tvalid,
   input  wire                                rsp_tready,
   // [30:0] region_begin_cs, [61:31] region_end_cs, [92:62] region_length,
   // [105:93] regions_found
   input  wire  [srd_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  wire  [srd_pkg::RspUserWidth-1:0]   rsp_tuser,   // [1:0] status, [2] region_valid
   input  wire                                csr_we,
   input  wire  [srd_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  wire  [srd_pkg::SpanWidth-1:0]      csr_wdata,
   output int                                 fail_total,
   output int                                 outstanding
);

   typedef struct packed {
      srd_pkg::status_type                 status;
      logic                                has_region;
      logic [srd_pkg::StampWidth-1:0]      first_cs;
      logic [srd_pkg::StampWidth-1:0]      last_cs;
      logic [srd_pkg::StampWidth-1:0]      region_len;
      logic [srd_pkg::FoundWidth-1:0]      count;
   } frame_answer_type;

   // control copy
   logic [srd_pkg::SpanWidth-1:0]   min_span_q;
   logic [srd_pkg::LimitWidth-1:0]  shot_limit_q;
   logic                            len_is_span_q;

   // run tracker copy
   logic [srd_pkg::StampWidth-1:0]  run_frames;
   logic [srd_pkg::ShotWidth-1:0]   shots;
   logic [srd_pkg::StampWidth-1:0]  run_first_cs;
   logic [srd_pkg::StampWidth-1:0]  run_last_cs;
   logic [srd_pkg::FoundWidth-1:0]  found_cnt;
   logic                            flushed;
   logic                            warming;

   frame_answer_type       frame_answer_q[$];
   int                     rsp_seen;

   function automatic frame_answer_type track_frame(logic [31:0] t, logic silent,
                                                    logic flush);
      frame_answer_type ans;
      longint           span;
      ans = '0;
      // negative stamp: stop, nothing moves, flush ignored
      if (t[31]) begin
         ans.status = srd_pkg::STATUS_STOP;
         ans.count  = found_cnt;
         return ans;
      end
      if (flush) flushed = 1'b1;
      if (!flushed && silent) begin
         if (run_frames == '0) run_first_cs = t[srd_pkg::StampWidth-1:0];
         if (!warming && run_frames != '1) run_frames = run_frames + 1'b1;
         if (shots < {1'b0, shot_limit_q}) shots = shots + 2'd2;
         run_last_cs = t[srd_pkg::StampWidth-1:0];
         ans.status  = srd_pkg::STATUS_CONTINUE;
         ans.count   = found_cnt;
         return ans;
      end
      if (run_frames > srd_pkg::MinRunFrames) begin
         if (flushed || shots == '0) begin
            span = longint'(run_last_cs) - longint'(run_first_cs);
            if (span >= longint'(min_span_q) && found_cnt < srd_pkg::MaxRegions) begin
               ans.has_region = 1'b1;
               ans.first_cs   = run_first_cs;
               ans.last_cs    = run_last_cs;
               ans.region_len = len_is_span_q ? span[srd_pkg::StampWidth-1:0] : run_frames;
               found_cnt      = found_cnt + 1'b1;
            end
            run_frames = '0;
            shots      = {1'b0, shot_limit_q};
         end
      end else begin
         run_frames = '0;
      end
      ans.count = found_cnt;
      if (flushed) begin
         ans.status = srd_pkg::STATUS_FLUSHED;
         return ans;
      end
      if (warming && shots == '0) warming = 1'b0;
      if (shots != '0) shots = shots - 1'b1;
      ans.status = (found_cnt >= srd_pkg::MaxRegions) ? srd_pkg::STATUS_STOP
                                                      : srd_pkg::STATUS_CONTINUE;
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      frame_answer_type want;
      frame_answer_type got;
      if (reset) begin
         min_span_q    = srd_pkg::MinSpanReset;
         shot_limit_q  = srd_pkg::ShotLimitReset;
         len_is_span_q = 1'b0;
         warming       = 1'b1;
         run_frames    = '0;
         shots         = {1'b0, srd_pkg::ShotLimitReset};
         run_first_cs  = '0;
         run_last_cs   = '0;
         found_cnt     = '0;
         flushed       = 1'b0;
         rsp_seen      = 0;
         fail_total    = 0;
         frame_answer_q.delete();
      end else begin
         if (csr_we) begin
            case (srd_pkg::csr_index_type'(csr_addr))
               srd_pkg::REG_MIN_SPAN_CS: min_span_q = csr_wdata;
               srd_pkg::REG_SHOT_LIMIT: begin
                  shot_limit_q = csr_wdata[srd_pkg::LimitWidth-1:0];
                  shots        = {1'b0, csr_wdata[srd_pkg::LimitWidth-1:0]};
               end
               srd_pkg::REG_LENGTH_AS_SPAN: len_is_span_q = csr_wdata[0];
               srd_pkg::REG_START_IN_WARMUP: warming = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            frame_answer_q.push_back(track_frame(req_tdata[31:0], req_tuser, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            got.status     = srd_pkg::status_type'(rsp_tuser[1:0]);
            got.has_region = rsp_tuser[2];
            got.first_cs   = rsp_tdata[30:0];
            got.last_cs    = rsp_tdata[61:31];
            got.region_len = rsp_tdata[92:62];
            got.count      = rsp_tdata[105:93];
            if (frame_answer_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("response %0d arrived with nothing awaited: status %0d valid %0d",
                           rsp_seen, rsp_tuser[1:0], rsp_tuser[2]);
            end else begin
               want = frame_answer_q.pop_front();
               if (got.status !== want.status || got.has_region !== want.has_region ||
                   got.first_cs !== want.first_cs || got.last_cs !== want.last_cs ||
                   got.region_len !== want.region_len || got.count !== want.count) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("response %0d mismatch", rsp_seen);
                     $display("  expected status %0d valid %0d begin %0d end %0d len %0d found %0d",
                              want.status, want.has_region, want.first_cs, want.last_cs,
                              want.region_len, want.count);
                     $display("  actual   status %0d valid %0d begin %0d end %0d len %0d found %0d",
                              rsp_tuser[1:0], got.has_region, got.first_cs, got.last_cs,
                              got.region_len, got.count);
                  end
               end
            end
            rsp_seen++;
         end
      end
      outstanding <= frame_answer_q.size();
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

   // generous ceiling: roughly 1.7k requests, each at worst a sender gap plus
   // a long receiver stall, taken several times over
   localparam int CycleLimit = 2_000_000;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [srd_pkg::ReqDataWidth-1:0]    req_tdata;   // [31:0] time_cs
   logic                                req_tuser;   // [0] silent
   logic                                req_tlast;   // flush_req
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   // [30:0] begin, [61:31] end, [92:62] length, [105:93] found, [111:106] zero
   logic [srd_pkg::RspDataWidth-1:0]    rsp_tdata;
   logic [srd_pkg::RspUserWidth-1:0]    rsp_tuser;   // [1:0] status, [2] region_valid
   logic                                csr_we;
   logic [srd_pkg::CsrAddrWidth-1:0]    csr_addr;
   logic [srd_pkg::SpanWidth-1:0]       csr_wdata;

   int                                  fail_total;
   int                                  outstanding;
   int                                  cycle_count = 0;
   int                                  burst_left;
   logic [srd_pkg::StampWidth-1:0]      stamp;

   silence_region_detector_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   srd_region_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_total  (fail_total),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on total cycles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one frame request; bursts of random length with random gaps in between,
   // valid stays up across back-to-back requests of a burst
   task automatic send_frame(input logic [31:0] t, input logic silent, input logic flush);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      req_tuser  <= silent;
      req_tlast  <= flush;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // hold the sender until every predicted response has come back
   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input srd_pkg::csr_index_type idx,
                            input logic [srd_pkg::SpanWidth-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // all four registers, unused upper write bits filled with junk
   task automatic load_settings(input logic [srd_pkg::SpanWidth-1:0] span,
                                input logic [7:0] limit,
                                input logic as_span, input logic warm);
      write_csr(srd_pkg::REG_MIN_SPAN_CS, span);
      write_csr(srd_pkg::REG_SHOT_LIMIT, {12'($urandom), limit});
      write_csr(srd_pkg::REG_LENGTH_AS_SPAN, {19'($urandom), as_span});
      write_csr(srd_pkg::REG_START_IN_WARMUP, {19'($urandom), warm});
      csr_we <= 1'b0;
   endtask

   // mostly well-formed silent and loud runs with rising time, plus noise,
   // time jumps and time going backwards
   task automatic play_random(input int n_items, input int loud_max);
      int           sent;
      int           len;
      int           step;
      int           kind;
      int           k;
      logic [31:0]  t;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 19);
         len  = 0;
         if (kind < 15) begin
            // silent runs are short around the minimum frame count, loud
            // runs scale with the hysteresis ceiling
            len  = (kind < 8) ? $urandom_range(1, 30) : $urandom_range(1, loud_max);
            step = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 300000)
                                               : $urandom_range(0, 3);
            for (k = 0; k < len; k++) begin
               stamp = stamp + srd_pkg::StampWidth'(step);
               send_frame({1'b0, stamp}, kind < 8, 1'b0);
            end
         end else if (kind < 18) begin
            // raw noise, half of it with a negative stamp; flush only rides
            // along with a negative stamp, where it is ignored
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
               t = $urandom;
               send_frame(t, 1'($urandom), t[31] & 1'($urandom));
            end
         end else if (kind == 18) begin
            stamp = srd_pkg::StampWidth'($urandom);
         end else begin
            stamp = stamp - srd_pkg::StampWidth'($urandom_range(1, 1000));
         end
         sent += len;
      end
   endtask

   // receiver: one long hold while the sender keeps offering, then a mix of
   // ready stretches, random stalls and the odd long hold
   initial begin : rsp_side
      int mode;
      int stretch;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset || !req_tvalid) @(posedge clock);
      repeat (300) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 19);
         if (mode < 8) begin
            stretch = $urandom_range(10, 80);
            repeat (stretch) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end
         end else if (mode < 16) begin
            stretch = $urandom_range(10, 60);
            repeat (stretch) begin
               rsp_tready <= ($urandom_range(0, 2) != 0);
               @(posedge clock);
            end
         end else begin
            stretch = (mode < 19) ? $urandom_range(1, 10) : $urandom_range(100, 250);
            repeat (stretch) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int k;
      int r;
      burst_left  = 0;
      stamp       = '0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= srd_pkg::REG_MIN_SPAN_CS;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no hysteresis, counting from the first frame, span as length
      load_settings(20'd0, 8'd0, 1'b1, 1'b0);
      // negative stamps answer stop; a flush riding on one is ignored
      send_frame(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_frame(32'h8000_0000, 1'b0, 1'b0);
      send_frame(32'h8000_0000, 1'b0, 1'b1);
      // run from time zero to the largest stamp: widest span and length
      for (k = 0; k < 10; k++) send_frame(32'(k), 1'b1, 1'b0);
      send_frame(32'h7FFF_FFFF, 1'b1, 1'b0);
      send_frame(32'h7FFF_FFFF, 1'b0, 1'b0);
      // run whose last frame lies before its first: negative span, dropped
      for (k = 0; k < 10; k++) send_frame(32'(1000 + k), 1'b1, 1'b0);
      send_frame(32'd5, 1'b1, 1'b0);
      send_frame(32'd6, 1'b0, 1'b0);
      drain_all();

      // random phases, each under its own settings
      load_settings(srd_pkg::MinSpanReset, srd_pkg::ShotLimitReset, 1'b0, 1'b1);
      play_random(300, 40);
      drain_all();
      load_settings(20'hF_FFFF, 8'd255, 1'b1, 1'b0);
      play_random(300, 270);
      drain_all();
      r = $urandom_range(0, 6);
      load_settings(20'($urandom_range(0, 60)), 8'(r), 1'($urandom), 1'($urandom));
      play_random(300, r + 15);
      drain_all();
      load_settings(20'd3, 8'd1, 1'b0, 1'b1);
      play_random(300, 16);
      drain_all();

      // back-to-back regions: eleven counted silent frames then one loud
      // frame closes a region each time
      load_settings(20'd0, 8'd0, 1'b0, 1'b0);
      send_frame({1'b0, stamp}, 1'b0, 1'b0);
      for (r = 0; r < 40; r++) begin
         for (k = 0; k < 11; k++) begin
            stamp = stamp + 1'b1;
            send_frame({1'b0, stamp}, 1'b1, 1'b0);
         end
         send_frame({1'b0, stamp}, 1'b0, 1'b0);
      end
      drain_all();

      // flush closes the open run and sticks from then on
      load_settings(20'd0, 8'd4, 1'b1, 1'b0);
      for (k = 0; k < 12; k++) begin
         stamp = stamp + 1'b1;
         send_frame({1'b0, stamp}, 1'b1, 1'b0);
      end
      send_frame({1'b0, stamp}, 1'b1, 1'b1);
      send_frame({1'b0, stamp + 1'b1}, 1'b1, 1'b0);
      send_frame(32'hFFFF_FFFE, 1'b0, 1'b1);
      send_frame({1'b0, stamp + 2'd2}, 1'b0, 1'b1);
      drain_all();
      repeat (10) @(posedge clock);

      if (fail_total == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/srd_pkg.sv
rtl/silence_region_detector_top.sv
tb/srd_region_checker.sv
tb/tb_top.sv
